// File: hw/rtl/dcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_pkg: shared types and constants of the decimal amount parser
// Character codes, field widths, the classified character word and the
// status codes used by the front, the back and the top level.
// ----------------------------------------------------------------------------
package dcp_pkg;

    // field widths
    localparam int CHAR_W  = 8;
    localparam int WHOLE_W = 50;
    localparam int FRAC_W  = 7;
    localparam int CENTS_W = 57;
    localparam int ICNT_W  = 5;
    localparam int FCNT_W  = 2;
    localparam int STAT_W  = 3;

    // saturation points of the digit counters
    localparam logic [ICNT_W-1:0] ICNT_SAT = 5'd31;
    localparam logic [FCNT_W-1:0] FCNT_SAT = 2'd3;
    // number of fraction digits kept
    localparam logic [FCNT_W-1:0] FRAC_DIGITS = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    // queue depths
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_SIGNED    = 3'd2,
        ST_MALFORMED = 3'd3,
        ST_RANGE     = 3'd4,
        ST_TRAIL_DOT = 3'd5,
        ST_FRAC_LONG = 3'd6
    } t_status;

    // classified character word, front to back
    typedef struct packed {
        logic       has_char;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_sign;
        logic       is_dot;
        logic       last;
    } t_cls;

    // result word, back to output queue
    typedef struct packed {
        logic [CENTS_W-1:0] cents;
        t_status            status;
    } t_result;

endpackage
`default_nettype wire

// File: hw/rtl/dcp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_fifo: small synchronous queue
// Register-based first-in first-out buffer with full and empty flags; a push
// and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module dcp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dcp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_front: character intake and classification
// Accepts one input word a cycle unless its held stage meets a full middle
// queue, sorts the character into digit, sign and dot classes and hands the
// classified word to the middle queue.
module dcp_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [dcp_pkg::CHAR_W-1:0] i_char_code,
    input  wire logic                       i_no_char,
    input  wire logic                       i_last,
    output logic                            o_full,
    output logic                            o_cls_valid,
    output dcp_pkg::t_cls                   o_cls,
    input  wire logic                       i_cls_full
);

    logic          r_valid, n_valid;
    dcp_pkg::t_cls r_cls, n_cls;
    logic          w_take;

    // stage is held only while the queue cannot take it
    assign o_full      = r_valid && i_cls_full;
    assign w_take      = i_push && !o_full;
    assign o_cls_valid = r_valid;
    assign o_cls       = r_cls;

    // classify the incoming character
    always_comb begin
        n_cls.has_char = !i_no_char;
        n_cls.is_digit = (i_char_code >= dcp_pkg::CH_ZERO) &&
                         (i_char_code <= dcp_pkg::CH_NINE);
        n_cls.digit    = n_cls.is_digit ? i_char_code[3:0] : 4'd0;
        n_cls.is_sign  = (i_char_code == dcp_pkg::CH_PLUS) ||
                         (i_char_code == dcp_pkg::CH_MINUS);
        n_cls.is_dot   = (i_char_code == dcp_pkg::CH_DOT);
        n_cls.last     = i_last;
    end

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_cls_full) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cls <= n_cls;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/dcp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dcp_back: accumulation and result stage
// Takes classified words from the middle queue, updates digit counts, flags
// and accumulators, settles the status at the end of a string and forms the
// cents value in a finishing register stage.
// ----------------------------------------------------------------------------
module dcp_back #(
    parameter int MAX_INT_DIGITS = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cls_valid,
    input  wire dcp_pkg::t_cls i_cls,
    output logic               o_cls_pop,
    output logic               o_res_valid,
    output dcp_pkg::t_result   o_res,
    input  wire logic          i_res_ready
);

    localparam logic [dcp_pkg::ICNT_W-1:0] MAX_CNT = dcp_pkg::ICNT_W'(MAX_INT_DIGITS);

    // per-string state
    logic                        r_at_first, n_at_first;
    logic                        r_sign, n_sign;
    logic [dcp_pkg::ICNT_W-1:0]  r_icnt, n_icnt;
    logic                        r_ibad, n_ibad;
    logic                        r_dot, n_dot;
    logic [dcp_pkg::FCNT_W-1:0]  r_fcnt, n_fcnt;
    logic                        r_fbad, n_fbad;
    logic [dcp_pkg::WHOLE_W-1:0] r_whole, n_whole;
    logic [dcp_pkg::FRAC_W-1:0]  r_frac, n_frac;

    // finishing stage
    logic                        r_fin_valid, n_fin_valid;
    dcp_pkg::t_status            r_fin_status, n_fin_status;
    logic [dcp_pkg::WHOLE_W-1:0] r_fin_whole;
    logic [dcp_pkg::FRAC_W-1:0]  r_fin_frac;
    logic                        r_fin_one;

    logic                        w_fin_free;
    logic                        w_take;
    logic                        w_end;
    logic [dcp_pkg::CENTS_W-1:0] w_w;
    logic [dcp_pkg::FRAC_W-1:0]  w_f;

    // a final word needs the finishing stage free
    assign w_fin_free = !r_fin_valid || i_res_ready;
    assign w_take     = i_cls_valid && (!i_cls.last || w_fin_free);
    assign w_end      = w_take && i_cls.last;
    assign o_cls_pop  = w_take;

    // character update
    always_comb begin
        n_at_first = r_at_first;
        n_sign     = r_sign;
        n_icnt     = r_icnt;
        n_ibad     = r_ibad;
        n_dot      = r_dot;
        n_fcnt     = r_fcnt;
        n_fbad     = r_fbad;
        n_whole    = r_whole;
        n_frac     = r_frac;
        if (w_take && i_cls.has_char) begin
            if (r_at_first && i_cls.is_sign) begin
                n_sign = 1'b1;
            end
            n_at_first = 1'b0;
            if (!r_dot) begin
                if (i_cls.is_dot) begin
                    n_dot = 1'b1;
                end else begin
                    if (i_cls.is_digit) begin
                        if (r_icnt < MAX_CNT) begin
                            n_whole = (r_whole << 3) + (r_whole << 1) +
                                      dcp_pkg::WHOLE_W'(i_cls.digit);
                        end
                    end else begin
                        n_ibad = 1'b1;
                    end
                    if (r_icnt < dcp_pkg::ICNT_SAT) begin
                        n_icnt = r_icnt + dcp_pkg::ICNT_W'(1);
                    end
                end
            end else begin
                if (i_cls.is_digit) begin
                    if (r_fcnt < dcp_pkg::FRAC_DIGITS) begin
                        n_frac = (r_frac << 3) + (r_frac << 1) +
                                 dcp_pkg::FRAC_W'(i_cls.digit);
                    end
                end else begin
                    n_fbad = 1'b1;
                end
                if (r_fcnt < dcp_pkg::FCNT_SAT) begin
                    n_fcnt = r_fcnt + dcp_pkg::FCNT_W'(1);
                end
            end
        end
    end

    // status by precedence, from the updated state
    always_comb begin
        if (n_at_first) begin
            n_fin_status = dcp_pkg::ST_EMPTY;
        end else if (n_sign) begin
            n_fin_status = dcp_pkg::ST_SIGNED;
        end else if (n_icnt == '0) begin
            n_fin_status = dcp_pkg::ST_MALFORMED;
        end else if (n_icnt > MAX_CNT) begin
            n_fin_status = dcp_pkg::ST_RANGE;
        end else if (n_ibad) begin
            n_fin_status = dcp_pkg::ST_MALFORMED;
        end else if (n_dot && (n_fcnt == '0)) begin
            n_fin_status = dcp_pkg::ST_TRAIL_DOT;
        end else if (n_dot && (n_fcnt > dcp_pkg::FRAC_DIGITS)) begin
            n_fin_status = dcp_pkg::ST_FRAC_LONG;
        end else if (n_dot && n_fbad) begin
            n_fin_status = dcp_pkg::ST_MALFORMED;
        end else begin
            n_fin_status = dcp_pkg::ST_OK;
        end
    end

    always_comb begin
        n_fin_valid = r_fin_valid;
        if (w_end) begin
            n_fin_valid = 1'b1;
        end else if (i_res_ready) begin
            n_fin_valid = 1'b0;
        end
    end

    // per-string state registers, cleared at end of string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_end) begin
            r_at_first <= 1'b1;
            r_sign     <= 1'b0;
            r_icnt     <= '0;
            r_ibad     <= 1'b0;
            r_dot      <= 1'b0;
            r_fcnt     <= '0;
            r_fbad     <= 1'b0;
            r_whole    <= '0;
            r_frac     <= '0;
        end else begin
            r_at_first <= n_at_first;
            r_sign     <= n_sign;
            r_icnt     <= n_icnt;
            r_ibad     <= n_ibad;
            r_dot      <= n_dot;
            r_fcnt     <= n_fcnt;
            r_fbad     <= n_fbad;
            r_whole    <= n_whole;
            r_frac     <= n_frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else begin
            r_fin_valid <= n_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_end) begin
            r_fin_status <= n_fin_status;
            r_fin_whole  <= n_whole;
            r_fin_frac   <= n_frac;
            r_fin_one    <= (n_fcnt == dcp_pkg::FCNT_W'(1));
        end
    end

    // cents = whole * 100 + fraction, a lone tenths digit scaled by ten
    assign w_w = dcp_pkg::CENTS_W'(r_fin_whole);
    assign w_f = r_fin_one ? ((r_fin_frac << 3) + (r_fin_frac << 1)) : r_fin_frac;

    always_comb begin
        o_res.status = r_fin_status;
        if (r_fin_status == dcp_pkg::ST_OK) begin
            o_res.cents = (w_w << 6) + (w_w << 5) + (w_w << 2) +
                          dcp_pkg::CENTS_W'(w_f);
        end else begin
            o_res.cents = '0;
        end
    end

    assign o_res_valid = r_fin_valid;

endmodule
`default_nettype wire

// File: hw/rtl/decimal_amount_to_cents_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_amount_to_cents_parser: decimal amount string to cents
// Top level: front classifier, middle queue, accumulating back end and
// output queue.
// ----------------------------------------------------------------------------
// The block takes one character word per cycle while full is low, through a
// push/full queue port, and gives one result word (cents and status) on the
// word marked last, through an empty/pop queue port. A result passes the front
// register, the middle queue and the finishing register to the output queue.
// The rate is set by the back end's multiply-by-ten accumulate, which takes one
// word a cycle but holds a last word until the finishing stage is free; a
// four-entry middle queue lets the front keep accepting while the back end waits
// for room in the two-entry output queue. Cents is zero whenever status is not ok.
module decimal_amount_to_cents_parser #(
    parameter int MAX_INT_DIGITS = 15
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [dcp_pkg::CHAR_W-1:0]  i_char_code,
    input  wire logic                        i_no_char,
    input  wire logic                        i_last,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [dcp_pkg::CENTS_W-1:0]      o_cents,
    output logic [dcp_pkg::STAT_W-1:0]       o_status
);

    logic             w_cls_valid;
    dcp_pkg::t_cls    w_cls;
    logic             w_mid_full;
    logic             w_mid_empty;
    dcp_pkg::t_cls    w_mid_cls;
    logic             w_mid_pop;
    logic             w_res_valid;
    dcp_pkg::t_result w_res;
    logic             w_out_full;
    dcp_pkg::t_result w_out_res;

    // front: intake and classification
    dcp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_char_code (i_char_code),
        .i_no_char   (i_no_char),
        .i_last      (i_last),
        .o_full      (full),
        .o_cls_valid (w_cls_valid),
        .o_cls       (w_cls),
        .i_cls_full  (w_mid_full)
    );

    // middle queue
    dcp_fifo #(
        .WIDTH ($bits(dcp_pkg::t_cls)),
        .DEPTH (dcp_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cls_valid),
        .i_data  (w_cls),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_cls),
        .o_empty (w_mid_empty)
    );

    // back: accumulate and finish
    dcp_back #(
        .MAX_INT_DIGITS (MAX_INT_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (!w_mid_empty),
        .i_cls       (w_mid_cls),
        .o_cls_pop   (w_mid_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (!w_out_full)
    );

    // output queue
    dcp_fifo #(
        .WIDTH ($bits(dcp_pkg::t_result)),
        .DEPTH (dcp_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_res),
        .o_empty (empty)
    );

    assign o_cents  = w_out_res.cents;
    assign o_status = w_out_res.status;

`ifndef SYNTHESIS
    // an error result never carries an amount
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status != dcp_pkg::ST_OK)) |-> (o_cents == '0))
        else $error("error result with nonzero cents");

    // a finished result pushed into the output queue shows up there
    a_res_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_out_full) |=> !empty)
        else $error("result lost on the way to the output queue");

    // input stalls only while the front stage holds a word
    a_full_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> (w_cls_valid && w_mid_full))
        else $error("input stalled with front stage free");
`endif

endmodule
`default_nettype wire

// File: tb/dcp_amount_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcp_amount_checker: result predictor and scoreboard for the cents parser
// Watches the character and result queue ports. Every word the parser takes
// runs through a local copy of the parse state. A word marked last queues the
// amount it should produce. Every popped result word is compared, field by
// field, with the oldest queued amount.
// ----------------------------------------------------------------------------
module dcp_amount_checker #(
    parameter int MAX_INT_DIGITS = 15
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire logic                        i_full,
    input  wire logic [dcp_pkg::CHAR_W-1:0]  i_char_code,
    input  wire logic                        i_no_char,
    input  wire logic                        i_last,
    input  wire logic                        i_empty,
    input  wire logic                        i_pop,
    input  wire logic [dcp_pkg::CENTS_W-1:0] i_cents,
    input  wire logic [dcp_pkg::STAT_W-1:0]  i_status,
    output int                               o_pending,
    output int                               o_errors
);

    // amounts still owed by the parser, oldest first
    dcp_pkg::t_result amounts_due[$];
    int               error_count = 0;

    // parse state of the string in progress
    logic                        at_first;
    logic                        sign_seen;
    logic [dcp_pkg::ICNT_W-1:0]  int_cnt;
    logic                        int_bad;
    logic                        dot_seen;
    logic [dcp_pkg::FCNT_W-1:0]  frac_cnt;
    logic                        frac_bad;
    logic [dcp_pkg::WHOLE_W-1:0] whole_acc;
    logic [dcp_pkg::FRAC_W-1:0]  frac_acc;

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    function void clear_amount();
        at_first  = 1'b1;
        sign_seen = 1'b0;
        int_cnt   = '0;
        int_bad   = 1'b0;
        dot_seen  = 1'b0;
        frac_cnt  = '0;
        frac_bad  = 1'b0;
        whole_acc = '0;
        frac_acc  = '0;
    endfunction

    // fold one character into the parse state
    function void take_char(input logic [dcp_pkg::CHAR_W-1:0] c);
        logic       is_digit;
        logic [3:0] d;
        is_digit = (c >= dcp_pkg::CH_ZERO) && (c <= dcp_pkg::CH_NINE);
        d = is_digit ? 4'(c - dcp_pkg::CH_ZERO) : 4'd0;

        // a sign counts only as the very first character
        if (at_first && (c == dcp_pkg::CH_PLUS || c == dcp_pkg::CH_MINUS)) begin
            sign_seen = 1'b1;
        end
        at_first = 1'b0;

        if (!dot_seen) begin
            if (c == dcp_pkg::CH_DOT) begin
                dot_seen = 1'b1;
            end else begin
                if (is_digit) begin
                    if (int_cnt < MAX_INT_DIGITS) begin
                        whole_acc = dcp_pkg::WHOLE_W'(whole_acc * 10 + d);
                    end
                end else begin
                    int_bad = 1'b1;
                end
                if (int_cnt != dcp_pkg::ICNT_SAT) begin
                    int_cnt = int_cnt + 1'b1;
                end
            end
        end else begin
            // later dots land here as bad fraction characters
            if (is_digit) begin
                if (frac_cnt < dcp_pkg::FRAC_DIGITS) begin
                    frac_acc = dcp_pkg::FRAC_W'(frac_acc * 10 + d);
                end
            end else begin
                frac_bad = 1'b1;
            end
            if (frac_cnt != dcp_pkg::FCNT_SAT) begin
                frac_cnt = frac_cnt + 1'b1;
            end
        end
    endfunction

    // status by precedence
    function dcp_pkg::t_status amount_status();
        if (at_first)                 return dcp_pkg::ST_EMPTY;
        if (sign_seen)                return dcp_pkg::ST_SIGNED;
        if (int_cnt == 0)             return dcp_pkg::ST_MALFORMED;
        if (int_cnt > MAX_INT_DIGITS) return dcp_pkg::ST_RANGE;
        if (int_bad)                  return dcp_pkg::ST_MALFORMED;
        if (dot_seen) begin
            if (frac_cnt == 0)                  return dcp_pkg::ST_TRAIL_DOT;
            if (frac_cnt > dcp_pkg::FRAC_DIGITS) return dcp_pkg::ST_FRAC_LONG;
            if (frac_bad)                       return dcp_pkg::ST_MALFORMED;
        end
        return dcp_pkg::ST_OK;
    endfunction

    // end of string: build the result word and start over
    function dcp_pkg::t_result close_amount();
        dcp_pkg::t_result res;
        logic [63:0]      tail;
        res.status = amount_status();
        res.cents  = '0;
        if (res.status == dcp_pkg::ST_OK) begin
            tail = 64'(frac_acc);
            // one fraction digit means tenths
            if (frac_cnt == 1) begin
                tail = tail * 10;
            end
            res.cents = dcp_pkg::CENTS_W'(64'(whole_acc) * 100 + tail);
        end
        clear_amount();
        return res;
    endfunction

    // watch both ports; the result side is checked first at each edge
    always @(posedge i_clk) begin : watch
        dcp_pkg::t_result want;
        dcp_pkg::t_result owed;
        if (!i_rst_n) begin
            clear_amount();
            amounts_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (amounts_due.size() == 0) begin
                    $display("%0t: unexpected result word: cents %0d status %0d",
                             $time, i_cents, i_status);
                    error_count++;
                end else begin
                    want = amounts_due.pop_front();
                    if (i_cents !== want.cents) begin
                        $display("%0t: cents mismatch: expected %0d, actual %0d",
                                 $time, want.cents, i_cents);
                        error_count++;
                    end
                    if (i_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_status);
                        error_count++;
                    end
                end
            end
            if (i_push && !i_full) begin
                if (!i_no_char) begin
                    take_char(i_char_code);
                end
                if (i_last) begin
                    owed = close_amount();
                    amounts_due = {amounts_due, owed};
                end
            end
        end
        o_pending <= amounts_due.size();
        o_errors  <= error_count;
    end

endmodule

// File: tb/tb_decimal_amount_to_cents_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_amount_to_cents_parser: regression for the cents parser
// Sends a short directed set of amount strings, then random strings in three
// flow-control phases, with a long result-side hold-off to fill the parser.
// The checker beside the parser predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_decimal_amount_to_cents_parser;

    localparam int MAX_INT_DIGITS = 15;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_ITEMS    = 200;

    // one character word as sent to the parser
    typedef struct packed {
        logic [dcp_pkg::CHAR_W-1:0] code;
        logic                       no_char;
        logic                       last;
    } t_word;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        push;
    logic                        full;
    logic [dcp_pkg::CHAR_W-1:0]  i_char_code;
    logic                        i_no_char;
    logic                        i_last;
    logic                        empty;
    logic                        pop;
    logic [dcp_pkg::CENTS_W-1:0] o_cents;
    logic [dcp_pkg::STAT_W-1:0]  o_status;

    int pending;
    int errors;
    int send_idle_pct = 15;
    int recv_idle_pct = 68;
    int items_sent    = 0;
    bit stall_req     = 1'b0;
    bit hold_done     = 1'b0;

    t_word line_q[$];

    decimal_amount_to_cents_parser #(
        .MAX_INT_DIGITS(MAX_INT_DIGITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_char_code (i_char_code),
        .i_no_char   (i_no_char),
        .i_last      (i_last),
        .empty       (empty),
        .pop         (pop),
        .o_cents     (o_cents),
        .o_status    (o_status)
    );

    dcp_amount_checker #(
        .MAX_INT_DIGITS(MAX_INT_DIGITS)
    ) u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_char_code (i_char_code),
        .i_no_char   (i_no_char),
        .i_last      (i_last),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_cents     (o_cents),
        .i_status    (o_status),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random pops, with one long hold-off on request
    initial begin : receiver
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                stall_req = 1'b0;
            end
            pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---- string building ----
    function void add_word(input logic [dcp_pkg::CHAR_W-1:0] c, input logic no_char,
                           input logic last);
        t_word w;
        w.code    = c;
        w.no_char = no_char;
        w.last    = last;
        line_q    = {line_q, w};
    endfunction

    function void put_char(input logic [dcp_pkg::CHAR_W-1:0] c);
        add_word(c, 1'b0, 1'b0);
    endfunction

    // word with no character, not last: parser ignores it
    function void put_gap();
        add_word(dcp_pkg::CHAR_W'($urandom_range(255)), 1'b1, 1'b0);
    endfunction

    function void put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            put_char(s[i]);
        end
    endfunction

    function void put_digits(input int n, input bit nines);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(15) == 0) begin
                put_gap();
            end
            put_char(nines ? dcp_pkg::CH_NINE :
                     dcp_pkg::CHAR_W'(dcp_pkg::CH_ZERO + $urandom_range(9)));
        end
    endfunction

    // mostly digits, with dots, signs and arbitrary bytes mixed in
    function logic [dcp_pkg::CHAR_W-1:0] noisy_char();
        int r;
        r = $urandom_range(9);
        if (r < 5)  return dcp_pkg::CHAR_W'(dcp_pkg::CH_ZERO + $urandom_range(9));
        if (r == 5) return dcp_pkg::CH_DOT;
        if (r == 6) return $urandom_range(1) ? dcp_pkg::CH_PLUS : dcp_pkg::CH_MINUS;
        return dcp_pkg::CHAR_W'($urandom_range(255));
    endfunction

    function void build_random_line();
        int kind;
        int n_int;
        int n_frac;
        bit nines;
        kind = $urandom_range(99);
        if (kind < 8) begin
            // empty string, maybe after ignored words
            if ($urandom_range(1)) begin
                put_gap();
            end
        end else if (kind < 18) begin
            // leading sign
            put_char($urandom_range(1) ? dcp_pkg::CH_PLUS : dcp_pkg::CH_MINUS);
            put_digits($urandom_range(0, 4), 1'b0);
        end else if (kind < 32) begin
            // broken content
            n_int = $urandom_range(1, 8);
            for (int i = 0; i < n_int; i++) begin
                put_char(noisy_char());
            end
        end else if (kind < 37) begin
            // long, often long enough to saturate the digit counters
            put_digits($urandom_range(25, 40), 1'b0);
            if ($urandom_range(1)) begin
                put_char(dcp_pkg::CH_DOT);
                put_digits($urandom_range(3, 6), 1'b0);
            end
        end else begin
            // well-formed amount, sometimes at or past the length limit
            case ($urandom_range(9))
                0: n_int = MAX_INT_DIGITS;
                1: n_int = $urandom_range(MAX_INT_DIGITS + 1, MAX_INT_DIGITS + 3);
                default: n_int = $urandom_range(1, 6);
            endcase
            nines = ($urandom_range(3) == 0);
            put_digits(n_int, nines);
            if ($urandom_range(2) != 0) begin
                put_char(dcp_pkg::CH_DOT);
                case ($urandom_range(7))
                    0: n_frac = 0;
                    1: n_frac = $urandom_range(3, 4);
                    default: n_frac = $urandom_range(1, 2);
                endcase
                put_digits(n_frac, nines);
            end
        end
    endfunction

    // ---- sending ----
    task automatic send_word(input t_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_char_code <= w.code;
        i_no_char   <= w.no_char;
        i_last      <= w.last;
        do @(posedge i_clk); while (full);
    endtask

    // mark the end of the string and send it
    task automatic send_line(input bit end_by_gap);
        if (end_by_gap || line_q.size() == 0) begin
            add_word(dcp_pkg::CHAR_W'($urandom_range(255)), 1'b1, 1'b1);
        end else begin
            line_q[line_q.size() - 1].last = 1'b1;
        end
        foreach (line_q[i]) begin
            send_word(line_q[i]);
            if (!(line_q[i].no_char && !line_q[i].last)) begin
                items_sent++;
            end
        end
        line_q.delete();
    endtask

    // stop sending until every queued amount has come back
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // ---- stimulus ----
    initial begin : stimulus
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_char_code <= '0;
        i_no_char   <= 1'b0;
        i_last      <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed strings
        send_line(1'b1);                     // empty string
        put_text("+5");   send_line(1'b0);   // leading plus
        put_text("-");    send_line(1'b0);   // lone minus
        put_text(".5");   send_line(1'b0);   // no integer digits
        put_text("7.");   send_line(1'b0);   // trailing dot
        put_text("1.234"); send_line(1'b0);  // fraction too long
        put_text("9.5");  send_line(1'b0);   // single fraction digit
        put_text("1"); put_char(8'hFF); send_line(1'b0);
        put_char(8'h00); send_line(1'b0);    // lowest byte
        put_text("2..");  send_line(1'b0);   // second dot
        put_text("0"); put_gap(); send_line(1'b1); // end on a word with no character
        drain();

        // random phases with different flow control
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 15; recv_idle_pct = 68; end
                1: begin send_idle_pct = 68; recv_idle_pct = 15; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            while (items_sent < (phase + 1) * PHASE_ITEMS) begin
                // long receiver hold-off while the sender keeps going
                if (phase == 0 && !hold_done && items_sent >= 60) begin
                    stall_req = 1'b1;
                    hold_done = 1'b1;
                end
                build_random_line();
                send_line($urandom_range(3) == 0);
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
